FILE: rtl/core/srkg_pkg.sv
// Shared types and constants for the small RSA key generator.
// No dependencies; srkg_div and small_rsa_key_generator_top import this package.
package srkg_pkg;

    localparam int SIEVE_SIZE = 256;
    localparam int IDX_W      = $clog2(SIEVE_SIZE);
    localparam int CNT_W      = IDX_W + 1;
    localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(SIEVE_SIZE - 1);

    localparam logic [7:0] LIMIT_RESET = 8'd100;
    localparam logic [7:0] LIMIT_MIN   = 8'd3;

    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;
    localparam int T_W    = 18;

    typedef struct packed {
        logic [30:0] first_pick;
        logic [30:0] second_pick;
    } t_in;

    typedef struct packed {
        logic [7:0]  first_prime;
        logic [7:0]  second_prime;
        logic [15:0] modulus;
        logic [7:0]  public_exp;
        logic [15:0] private_exp;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_SV_RD,
        ST_SV_CHK,
        ST_SV_MARK,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_MOD_ST,
        ST_MOD_WT,
        ST_TK_RD,
        ST_TK_CHK,
        ST_G_TEST,
        ST_G_WT,
        ST_L_WT,
        ST_L_MUL,
        ST_E_INIT,
        ST_E_TEST,
        ST_E_WT,
        ST_E_MUL,
        ST_E_UPD,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/core/srkg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srkg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/srkg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srkg_pkg for the dividend and divisor widths.
module srkg_div import srkg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot,
    output logic [DIV_DW-1:0] o_rem
);

    localparam int STEP_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem[DIV_DW-1:0], r_quo[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[DIV_DW-1:0];

endmodule

FILE: rtl/core/small_rsa_key_generator_top.sv
// Small RSA key generator: sieve in a 256 x 1 RAM, shared serial divider for
// all modulo, gcd, lambda and extended Euclid steps. A request clears the map,
// marks the sieve, scans the map to count primes, and per pick takes a modulo
// and scans the map again. One request is in work at a time; a finished key
// waits in the output register.
// Reset sets the limit to 100 and clears the output valid.
module small_rsa_key_generator_top import srkg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [7:0]  r_limit;
    logic [7:0]  r_lim, n_lim;
    t_in         r_req, n_req;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    logic [7:0]  r_cnt, n_cnt, r_k, n_k, r_p, n_p, r_q, n_q, r_e, n_e;
    logic        r_sel, n_sel;
    logic [15:0] r_r0, n_r0, r_r1, n_r1, r_quo, n_quo, r_lambda, n_lambda;
    logic signed [T_W-1:0] r_t0, n_t0, r_t1, n_t1, r_qt, n_qt;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic              ram_we, ram_wdata, ram_rdata;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den, div_rem;

    logic [9:0]  w_sq;
    logic signed [34:0] w_prod;
    logic signed [T_W-1:0] w_inv, w_d;

    srkg_ram #(.WIDTH(1), .DEPTH(SIEVE_SIZE)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    srkg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign w_sq   = r_i[4:0] * r_i[4:0];
    assign w_prod = $signed({1'b0, r_quo}) * r_t1;
    assign w_inv  = r_t0[T_W-1] ? (r_t0 + $signed({2'b0, r_lambda})) : r_t0;
    // The smallest d of at least 2 is the inverse itself or one period above it.
    assign w_d    = (w_inv < 2) ? (w_inv + $signed({2'b0, r_lambda})) : w_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_req    <= n_req;
        r_i      <= n_i;
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_p      <= n_p;
        r_q      <= n_q;
        r_e      <= n_e;
        r_sel    <= n_sel;
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_quo    <= n_quo;
        r_lambda <= n_lambda;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_qt     <= n_qt;
        r_out    <= n_out;
    end

    always_comb begin
        n_state = r_state;  n_lim = r_lim;  n_req = r_req;
        n_i = r_i;  n_j = r_j;  n_cnt = r_cnt;  n_k = r_k;
        n_p = r_p;  n_q = r_q;  n_e = r_e;  n_sel = r_sel;
        n_r0 = r_r0;  n_r1 = r_r1;  n_quo = r_quo;  n_lambda = r_lambda;
        n_t0 = r_t0;  n_t1 = r_t1;  n_qt = r_qt;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready = 1'b0;
        ram_we = 1'b0;  ram_waddr = r_i[IDX_W-1:0];  ram_wdata = 1'b0;
        ram_raddr = r_i[IDX_W-1:0];
        div_start = 1'b0;
        div_num = {16'b0, r_r0};
        div_den = r_r1;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_lim   = (r_limit < LIMIT_MIN) ? LIMIT_MIN : r_limit;
                    n_i     = '0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = (r_i >= CNT_W'(2)) && (r_i <= {1'b0, r_lim});
                n_i = r_i + 1'b1;
                if (r_i == IDX_LAST) begin
                    n_i     = CNT_W'(2);
                    n_state = ST_SV_RD;
                end
            end
            ST_SV_RD: begin
                if (w_sq > {2'b0, r_lim}) begin
                    n_i     = '0;
                    n_cnt   = '0;
                    n_state = ST_CNT_RD;
                end else begin
                    n_state = ST_SV_CHK;
                end
            end
            ST_SV_CHK: begin
                if (ram_rdata) begin
                    n_j     = w_sq[CNT_W-1:0];
                    n_state = ST_SV_MARK;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SV_RD;
                end
            end
            ST_SV_MARK: begin
                if (r_j > {1'b0, r_lim}) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SV_RD;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[IDX_W-1:0];
                    n_j       = r_j + r_i;
                end
            end
            ST_CNT_RD: begin
                n_state = ST_CNT_CHK;
            end
            ST_CNT_CHK: begin
                if (ram_rdata) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = ST_CNT_RD;
                if (r_i == IDX_LAST) begin
                    n_sel   = 1'b0;
                    n_state = ST_MOD_ST;
                end
            end
            ST_MOD_ST: begin
                div_start = 1'b1;
                div_num   = r_sel ? {1'b0, r_req.second_pick} : {1'b0, r_req.first_pick};
                div_den   = r_sel ? {8'b0, r_cnt - 1'b1} : {8'b0, r_cnt};
                n_state   = ST_MOD_WT;
            end
            ST_MOD_WT: begin
                if (div_done) begin
                    n_k     = div_rem[7:0];
                    n_i     = '0;
                    n_state = ST_TK_RD;
                end
            end
            ST_TK_RD: begin
                n_state = ST_TK_CHK;
            end
            ST_TK_CHK: begin
                n_i     = r_i + 1'b1;
                n_state = ST_TK_RD;
                if (ram_rdata) begin
                    if (r_k == 8'd0) begin
                        ram_we = 1'b1;
                        if (r_sel) begin
                            n_q     = r_i[7:0];
                            n_r0    = {8'b0, r_p - 1'b1};
                            n_r1    = {8'b0, r_i[7:0] - 1'b1};
                            n_state = ST_G_TEST;
                        end else begin
                            n_p     = r_i[7:0];
                            n_sel   = 1'b1;
                            n_state = ST_MOD_ST;
                        end
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            ST_G_TEST: begin
                div_start = 1'b1;
                if (r_r1 == 16'd0) begin
                    // gcd found in r0: divide p-1 by it.
                    div_num = {24'b0, r_p - 1'b1};
                    div_den = r_r0;
                    n_state = ST_L_WT;
                end else begin
                    n_state = ST_G_WT;
                end
            end
            ST_G_WT: begin
                if (div_done) begin
                    n_r0    = r_r1;
                    n_r1    = div_rem;
                    n_state = ST_G_TEST;
                end
            end
            ST_L_WT: begin
                if (div_done) begin
                    n_quo   = div_quot[15:0];
                    n_state = ST_L_MUL;
                end
            end
            ST_L_MUL: begin
                n_lambda = r_quo[7:0] * (r_q - 1'b1);
                n_e      = 8'd2;
                n_state  = ST_E_INIT;
            end
            ST_E_INIT: begin
                n_r0    = r_lambda;
                n_r1    = {8'b0, r_e};
                n_t0    = '0;
                n_t1    = T_W'(1);
                n_state = ST_E_TEST;
            end
            ST_E_TEST: begin
                if (r_r1 == 16'd0) begin
                    if (r_r0 == 16'd1) begin
                        n_state = ST_OUT;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = ST_E_INIT;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_E_WT;
                end
            end
            ST_E_WT: begin
                if (div_done) begin
                    n_quo   = div_quot[15:0];
                    n_r0    = r_r1;
                    n_r1    = div_rem;
                    n_state = ST_E_MUL;
                end
            end
            ST_E_MUL: begin
                n_qt    = w_prod[T_W-1:0];
                n_state = ST_E_UPD;
            end
            ST_E_UPD: begin
                n_t0    = r_t1;
                n_t1    = r_t0 - r_qt;
                n_state = ST_E_TEST;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.first_prime  = r_p;
                    n_out.second_prime = r_q;
                    n_out.modulus      = r_p * r_q;
                    n_out.public_exp   = r_e;
                    n_out.private_exp  = w_d[15:0];
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: bench/tb.sv
// Testbench for the small RSA key generator: directed table, then random requests.
// Depends on srkg_pkg and small_rsa_key_generator_top from rtl/core.
`timescale 1ns / 100ps

module tb import srkg_pkg::*; ();

    localparam int LONG_STALL = 20000;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_RANDOM = 150;

    typedef struct {
        logic [7:0]  limit;
        logic        set_limit;
        logic [30:0] pick_a;
        logic [30:0] pick_b;
        logic        typed;
        t_out        key;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in        i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;

    t_out   key_queue[$];
    logic [7:0] limit_reg = LIMIT_RESET;
    int     errors = 0;
    int     cycles = 0;
    bit     hold_sink = 1'b0;
    bit     stim_done = 1'b0;
    t_row   rows[$];

    small_rsa_key_generator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int gcd_of(int a, int b);
        int t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Predicts the key for one request under the current prime limit.
    function automatic t_out predict_key(logic [7:0] lim_reg, logic [30:0] pa, logic [30:0] pb);
        bit   is_prime[SIEVE_SIZE];
        int   lim, count, k, p, q, lam, e, d, r;
        t_out res;
        lim = lim_reg;
        if (lim < LIMIT_MIN) lim = LIMIT_MIN;
        if (lim > SIEVE_SIZE - 1) lim = SIEVE_SIZE - 1;
        foreach (is_prime[i]) is_prime[i] = (i >= 2 && i <= lim);
        for (int i = 2; i * i <= lim; i++)
            if (is_prime[i])
                for (int j = i * i; j <= lim; j += i) is_prime[j] = 0;
        count = 0;
        foreach (is_prime[i]) if (is_prime[i]) count++;
        p = 0;
        q = 0;
        k = int'(pa) % count;
        foreach (is_prime[i]) begin
            if (is_prime[i] && p == 0) begin
                if (k == 0) begin
                    p = i;
                    is_prime[i] = 0;
                end else begin
                    k--;
                end
            end
        end
        k = int'(pb) % (count - 1);
        foreach (is_prime[i]) begin
            if (is_prime[i] && q == 0) begin
                if (k == 0) q = i;
                else k--;
            end
        end
        lam = ((p - 1) / gcd_of(p - 1, q - 1)) * (q - 1);
        e = 2;
        while (gcd_of(e, lam) != 1) e++;
        d = 2;
        r = (2 * (e % lam)) % lam;
        while (r != 1) begin
            r = (r + e % lam) % lam;
            d++;
        end
        res.first_prime = p[7:0];
        res.second_prime = q[7:0];
        res.modulus = 16'(p * q);
        res.public_exp = e[7:0];
        res.private_exp = d[15:0];
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic add_row(logic set, logic [7:0] lim, logic [30:0] pa, logic [30:0] pb,
                           logic typed, t_out key);
        t_row r;
        r.set_limit = set;
        r.limit = lim;
        r.pick_a = pa;
        r.pick_b = pb;
        r.typed = typed;
        r.key = key;
        rows.push_back(r);
    endtask

    task automatic wait_drained();
        while (key_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [7:0] lim);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = lim;
    endtask

    // Valid drops after each accepted request.
    task automatic send_request(logic [30:0] pa, logic [30:0] pb, logic typed, t_out key);
        t_out want;
        want = typed ? key : predict_key(limit_reg, pa, pb);
        i_in_valid <= 1'b1;
        i_in <= '{first_pick: pa, second_pick: pb};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        key_queue.push_back(want);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed table; typed keys are obvious by hand.
    initial begin
        add_row(0, 0, 31'd0, 31'd0, 1, '{8'd2, 8'd3, 16'd6, 8'd3, 16'd3});
        add_row(0, 0, '1, '1, 0, '0);
        add_row(0, 0, 31'h2AAAAAAA, 31'h55555555, 0, '0);
        add_row(1, 8'd0, 31'd0, 31'd0, 1, '{8'd2, 8'd3, 16'd6, 8'd3, 16'd3});
        add_row(0, 0, 31'd1, 31'd0, 1, '{8'd3, 8'd2, 16'd6, 8'd3, 16'd3});
        add_row(1, 8'd2, '1, '1, 0, '0);
        add_row(1, 8'd3, 31'd1, 31'd1, 0, '0);
        add_row(1, 8'd255, '1, 31'd0, 0, '0);
        add_row(0, 0, 31'd53, 31'd52, 0, '0);
        add_row(0, 0, 31'd12345, 31'd777, 0, '0);
        add_row(1, 8'd254, 31'd7, 31'd9, 0, '0);
        add_row(1, 8'd1, 31'd5, 31'd5, 0, '0);
        add_row(1, 8'd100, 31'd24, 31'd23, 0, '0);
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            if (rows[i].set_limit) write_limit(rows[i].limit);
            send_request(rows[i].pick_a, rows[i].pick_b, rows[i].typed, rows[i].key);
            repeat (gap_len()) @(posedge i_clk);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 25 == 0) begin
                // Small limits half the time; otherwise the extremes or any value.
                case ($urandom_range(0, 3))
                    0: write_limit(8'($urandom_range(0, 255)));
                    1: write_limit($urandom_range(0, 1) ? 8'd255 : 8'd0);
                    default: write_limit(8'($urandom_range(3, 40)));
                endcase
            end
            if (n == 40) hold_sink = 1'b1;
            if (n == 80) wait_drained();
            send_request(31'($urandom), 31'($urandom), 0, '0);
            repeat (gap_len()) @(posedge i_clk);
        end
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while requests keep coming.
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                i_out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            stall = gap_len();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (key_queue.size() == 0) begin
                $error("key with no request outstanding: %h", o_out);
                errors++;
            end else begin
                want = key_queue.pop_front();
                if (o_out.first_prime !== want.first_prime) begin
                    $error("first_prime: expected %0d, got %0d",
                           want.first_prime, o_out.first_prime);
                    errors++;
                end
                if (o_out.second_prime !== want.second_prime) begin
                    $error("second_prime: expected %0d, got %0d",
                           want.second_prime, o_out.second_prime);
                    errors++;
                end
                if (o_out.modulus !== want.modulus) begin
                    $error("modulus: expected %0d, got %0d", want.modulus, o_out.modulus);
                    errors++;
                end
                if (o_out.public_exp !== want.public_exp) begin
                    $error("public_exp: expected %0d, got %0d",
                           want.public_exp, o_out.public_exp);
                    errors++;
                end
                if (o_out.private_exp !== want.private_exp) begin
                    $error("private_exp: expected %0d, got %0d",
                           want.private_exp, o_out.private_exp);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (key_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end
endmodule

FILE: filelist.f
rtl/core/srkg_pkg.sv
rtl/core/srkg_ram.sv
rtl/core/srkg_div.sv
rtl/core/small_rsa_key_generator_top.sv
bench/tb.sv
